@@ rtl/core/assert_macros.svh @@
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, ck, rs, expr) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) \
    else $error("%m: forbidden condition seen");

// antecedent in one cycle requires consequent in the next
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("%m: expected condition missing one cycle later");

// antecedent requires consequent in the same cycle
`define ASSERT_IMPLIES(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`endif

@@ rtl/core/hil_pkg.sv @@
`default_nettype none

package hil_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_SEARCH,
    PH_HEAD,
    PH_DATA,
    PH_CKSUM,
    PH_TERM,
    PH_SKIP,
    PH_STOP
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_BAD_HEX    = 3'd0,
    ERR_BAD_RECORD = 3'd1,
    ERR_BAD_CKSUM  = 3'd2,
    ERR_BUF_SMALL  = 3'd3,
    ERR_NO_END     = 3'd4
  } err_t;

  // configuration register indexes
  localparam logic [1:0] REG_BUFFER_SIZE = 2'd0;
  localparam logic [1:0] REG_INIT_MIN    = 2'd1;
  localparam logic [1:0] REG_INIT_MAX    = 2'd2;

  // header fields in order of arrival
  localparam logic [1:0] FLD_LENGTH  = 2'd0;
  localparam logic [1:0] FLD_ADDR_HI = 2'd1;
  localparam logic [1:0] FLD_ADDR_LO = 2'd2;
  localparam logic [1:0] FLD_TYPE    = 2'd3;

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] REC_DATA   = 8'h00;
  localparam logic [7:0] REC_EOF    = 8'h01;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  data;
    err_t        error_code;
    logic [15:0] lowest_address;
    logic [15:0] highest_address;
  } result_t;

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    return v;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/hil_out_buf.sv @@
`default_nettype none

`include "assert_macros.svh"

module hil_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire hil_pkg::result_t push_word,
  output logic                  full,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output hil_pkg::result_t      m_word
);

  hil_pkg::result_t slot0;
  hil_pkg::result_t slot1;
  logic [1:0]       count;
  logic             pop;

  assign pop      = (count != 2'd0) && m_tready;
  assign full     = (count == 2'd2);
  assign m_tvalid = (count != 2'd0);
  assign m_word   = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // slot0 is the head word shown on the master side
  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) slot0 <= push_word;
        else slot1 <= push_word;
      end
      2'b01: begin
        slot0 <= slot1;
      end
      2'b11: begin
        if (count == 2'd1) begin
          slot0 <= push_word;
        end else begin
          slot0 <= slot1;
          slot1 <= push_word;
        end
      end
      default: begin
      end
    endcase
  end

  `ASSERT_NEVER(a_push_when_full, clk, rst, push && full)
  `ASSERT_NEVER(a_count_range, clk, rst, count == 2'd3)
  `ASSERT_NEXT(a_held_word_stays, clk, rst, m_tvalid && !m_tready && count == 2'd1, m_tvalid)

endmodule

`default_nettype wire

@@ rtl/core/hex_image_loader_unit.sv @@
// intel hex loader: parses a hex text stream one character per word.
// slave side: s_tdata carries one ascii character, s_tlast marks the end
// of the stream (the character is then ignored). master side: one result
// word per data byte, one at the end record, one at the first error.
// m_tuser holds the result kind (data write, end reached, error).
// a word is accepted each cycle s_tready is high; its result, if any, joins
// the output buffer behind earlier words. parsing state is updated in the
// same cycle a character is taken; one character per clock when not full.
// results queue in a two-word output buffer: the slave side keeps taking
// characters while the receiver stalls, and s_tready drops only once both
// buffer words are occupied.
// after the end record or an error the block stops and emits nothing
// until reset. reset (rst, synchronous) restores buffer_size 65536,
// lowest 65535, highest 0 and the search for the first colon.
// configuration writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at
// once and belong only to idle periods; writing a start address register
// also reloads the tracked minimum or maximum.

`default_nettype none

`include "assert_macros.svh"

module hex_image_loader_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // character
  input  wire logic        s_tlast,   // end_of_input
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // address, data, error_code, lowest, highest, zero fill
  output logic [1:0]       m_tuser    // kind
);

  logic [16:0]      buffer_size;
  logic [15:0]      init_min;
  logic [15:0]      init_max;

  hil_pkg::phase_t  phase, phase_next;
  logic [3:0]       high_nibble, high_nibble_next;
  logic             nibble_pending, nibble_pending_next;
  logic [1:0]       field_index, field_index_next;
  logic [7:0]       bytes_left, bytes_left_next;
  logic [15:0]      record_address, record_address_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [15:0]      min_seen, min_seen_next;
  logic [15:0]      max_seen, max_seen_next;

  logic             accept;
  logic             full;
  logic             push;
  logic             fail;
  hil_pkg::err_t    fail_code;
  hil_pkg::result_t res;
  hil_pkg::result_t m_word;
  logic [4:0]       hv;
  logic [7:0]       byte_val;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;
  assign hv       = hil_pkg::hex_value(s_tdata);
  assign byte_val = {high_nibble, hv[3:0]};

  always_comb begin
    phase_next          = phase;
    high_nibble_next    = high_nibble;
    nibble_pending_next = nibble_pending;
    field_index_next    = field_index;
    bytes_left_next     = bytes_left;
    record_address_next = record_address;
    running_sum_next    = running_sum;
    min_seen_next       = min_seen;
    max_seen_next       = max_seen;
    push                = 1'b0;
    fail                = 1'b0;
    fail_code           = hil_pkg::ERR_BAD_HEX;
    res                 = '0;

    unique case (phase)
      hil_pkg::PH_START, hil_pkg::PH_SEARCH: begin
        if (s_tlast) begin
          fail      = 1'b1;
          fail_code = (phase == hil_pkg::PH_START) ? hil_pkg::ERR_NO_END
                                                   : hil_pkg::ERR_BAD_RECORD;
        end else if (s_tdata == hil_pkg::CHAR_COLON) begin
          phase_next          = hil_pkg::PH_HEAD;
          field_index_next    = hil_pkg::FLD_LENGTH;
          nibble_pending_next = 1'b0;
          running_sum_next    = 8'd0;
        end else if (s_tdata == hil_pkg::CHAR_NUL || s_tdata == hil_pkg::CHAR_LF) begin
          fail      = 1'b1;
          fail_code = hil_pkg::ERR_BAD_RECORD;
        end else begin
          phase_next = hil_pkg::PH_SEARCH;
        end
      end
      hil_pkg::PH_SKIP: begin
        if (s_tlast) begin
          fail      = 1'b1;
          fail_code = hil_pkg::ERR_NO_END;
        end else if (s_tdata == hil_pkg::CHAR_LF) begin
          phase_next = hil_pkg::PH_START;
        end
      end
      hil_pkg::PH_TERM: begin
        if (s_tlast) begin
          fail      = 1'b1;
          fail_code = hil_pkg::ERR_NO_END;
        end else if (s_tdata == hil_pkg::CHAR_LF) begin
          phase_next = hil_pkg::PH_START;
        end else if (s_tdata == hil_pkg::CHAR_NUL) begin
          phase_next = hil_pkg::PH_SKIP;
        end else begin
          fail      = 1'b1;
          fail_code = hil_pkg::ERR_BAD_RECORD;
        end
      end
      hil_pkg::PH_HEAD, hil_pkg::PH_DATA, hil_pkg::PH_CKSUM: begin
        // address bookkeeping happens when a data byte starts
        if (phase == hil_pkg::PH_DATA && !nibble_pending) begin
          if (record_address < min_seen) min_seen_next = record_address;
          if (record_address > max_seen) max_seen_next = record_address;
          if ({1'b0, record_address} >= buffer_size) begin
            fail      = 1'b1;
            fail_code = hil_pkg::ERR_BUF_SMALL;
          end
        end
        if (!fail) begin
          if (s_tlast || hv[4]) begin
            fail      = 1'b1;
            fail_code = hil_pkg::ERR_BAD_HEX;
          end else if (!nibble_pending) begin
            high_nibble_next    = hv[3:0];
            nibble_pending_next = 1'b1;
          end else begin
            nibble_pending_next = 1'b0;
            running_sum_next    = running_sum + byte_val;
            if (phase == hil_pkg::PH_HEAD) begin
              field_index_next = field_index + 2'd1;
              case (field_index)
                hil_pkg::FLD_LENGTH:  bytes_left_next = byte_val;
                hil_pkg::FLD_ADDR_HI: record_address_next = {byte_val, 8'h00};
                hil_pkg::FLD_ADDR_LO: record_address_next = {record_address[15:8], byte_val};
                default: begin
                  if (byte_val == hil_pkg::REC_DATA) begin
                    phase_next = (bytes_left != 8'd0) ? hil_pkg::PH_DATA
                                                      : hil_pkg::PH_CKSUM;
                  end else if (byte_val == hil_pkg::REC_EOF) begin
                    phase_next          = hil_pkg::PH_STOP;
                    push                = 1'b1;
                    res.kind            = hil_pkg::KIND_END;
                    res.lowest_address  = min_seen;
                    res.highest_address = max_seen;
                  end else begin
                    phase_next = hil_pkg::PH_SKIP;
                  end
                end
              endcase
            end else if (phase == hil_pkg::PH_DATA) begin
              push                = 1'b1;
              res.kind            = hil_pkg::KIND_DATA;
              res.address         = record_address;
              res.data            = byte_val;
              record_address_next = record_address + 16'd1;
              bytes_left_next     = bytes_left - 8'd1;
              if (bytes_left == 8'd1) phase_next = hil_pkg::PH_CKSUM;
            end else begin
              if (running_sum_next != 8'd0) begin
                fail      = 1'b1;
                fail_code = hil_pkg::ERR_BAD_CKSUM;
              end else begin
                phase_next = hil_pkg::PH_TERM;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (fail) begin
      phase_next          = hil_pkg::PH_STOP;
      push                = 1'b1;
      res                 = '0;
      res.kind            = hil_pkg::KIND_ERROR;
      res.error_code      = fail_code;
      res.lowest_address  = min_seen_next;
      res.highest_address = max_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_size    <= 17'h10000;
      init_min       <= 16'hFFFF;
      init_max       <= 16'h0000;
      phase          <= hil_pkg::PH_START;
      high_nibble    <= 4'd0;
      nibble_pending <= 1'b0;
      field_index    <= hil_pkg::FLD_LENGTH;
      bytes_left     <= 8'd0;
      record_address <= 16'd0;
      running_sum    <= 8'd0;
      min_seen       <= 16'hFFFF;
      max_seen       <= 16'h0000;
    end else begin
      if (accept) begin
        phase          <= phase_next;
        high_nibble    <= high_nibble_next;
        nibble_pending <= nibble_pending_next;
        field_index    <= field_index_next;
        bytes_left     <= bytes_left_next;
        record_address <= record_address_next;
        running_sum    <= running_sum_next;
        min_seen       <= min_seen_next;
        max_seen       <= max_seen_next;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          hil_pkg::REG_BUFFER_SIZE: buffer_size <= cfg_wdata;
          hil_pkg::REG_INIT_MIN: begin
            init_min <= cfg_wdata[15:0];
            min_seen <= cfg_wdata[15:0];
          end
          hil_pkg::REG_INIT_MAX: begin
            init_max <= cfg_wdata[15:0];
            max_seen <= cfg_wdata[15:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  hil_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && push),
    .push_word (res),
    .full      (full),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_word    (m_word)
  );

  assign m_tuser = m_word.kind;
  assign m_tdata = {5'd0, m_word.highest_address, m_word.lowest_address,
                    m_word.error_code, m_word.data, m_word.address};

  `ASSERT_NEXT(a_stop_sticks, clk, rst, phase == hil_pkg::PH_STOP, phase == hil_pkg::PH_STOP)
  `ASSERT_NEVER(a_no_word_when_stopped, clk, rst, phase == hil_pkg::PH_STOP && push)
  `ASSERT_IMPLIES(a_data_only_in_data, clk, rst, push && res.kind == hil_pkg::KIND_DATA, phase == hil_pkg::PH_DATA)
  `ASSERT_IMPLIES(a_min_tracking, clk, rst, init_min == min_seen && init_max == max_seen && phase == hil_pkg::PH_START && bytes_left == 8'd0 && record_address == 16'd0 && running_sum == 8'd0, min_seen <= init_min)

endmodule

`default_nettype wire
